/* rtl/rbcd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbcd_pkg: shared types and constants
// Constants and control struct for the real by complex divider.
// ----------------------------------------------------------------------------
package rbcd_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS       = 16;
    // quotient bits of |num| * 2^(FRAC_BITS+1) / den, one more for rounding
    localparam int QBITS           = 33;
    localparam int OUT_BITS        = 32;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SAT      = 2'd1,
        STATUS_DIV_ZERO = 2'd2
    } status_t;

    // control bits that ride along with every transaction
    typedef struct packed {
        logic       valid;
        logic       last;
        logic       zero;
        logic [1:0] ovf;
        logic [1:0] neg;
    } rbcd_ctl_t;

endpackage

/* rtl/rbcd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbcd_front: magnitude, product and denominator stages
// Four stages that turn a sample triple into numerators, |b|^2 and the
// first partial remainders for the divider cells.
// ----------------------------------------------------------------------------
module rbcd_front #(
    parameter int SB = rbcd_pkg::SAMPLE_BITS_DEF,
    localparam int RW = 2 * SB + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic                   in_last,
    input  logic [SB-1:0]          a_in,
    input  logic [SB-1:0]          br_in,
    input  logic [SB-1:0]          bi_in,
    output rbcd_pkg::rbcd_ctl_t    ctl_out,
    output logic [2*SB-1:0]        den_out,
    output logic [1:0][RW-1:0]     rem_out,
    output logic [1:0][rbcd_pkg::FRAC_BITS-1:0] lo_out
);
    import rbcd_pkg::*;

    logic [3:0]      valid_reg;
    logic [3:0]      last_reg;
    logic [SB-1:0]   ma_reg, mr_reg, mi_reg;
    logic            na_reg, nr_reg, ni_reg;
    logic [2*SB-1:0] par_reg, pai_reg, prr_reg, pii_reg;
    logic [1:0]      neg2_reg, neg3_reg, neg4_reg;
    logic [2*SB-1:0] numr_reg, numi_reg, den3_reg, den4_reg;
    logic [1:0][RW-1:0] rem_reg;
    logic [1:0][FRAC_BITS-1:0] lo_reg;
    logic [1:0]      ovf_reg;
    logic            zero_reg;
    logic [RW-1:0]   r0r, r0i;

    // valid and last pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg <= {last_reg[2:0], in_last};
        end
    end

    // stage 1: magnitudes and signs
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            na_reg <= a_in[SB-1];
            nr_reg <= br_in[SB-1];
            ni_reg <= bi_in[SB-1];
            ma_reg <= a_in[SB-1] ? (SB'(0) - a_in) : a_in;
            mr_reg <= br_in[SB-1] ? (SB'(0) - br_in) : br_in;
            mi_reg <= bi_in[SB-1] ? (SB'(0) - bi_in) : bi_in;
        end
    end

    // stage 2: products, one multiplier each
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            par_reg  <= (2*SB)'(ma_reg) * (2*SB)'(mr_reg);
            pai_reg  <= (2*SB)'(ma_reg) * (2*SB)'(mi_reg);
            prr_reg  <= (2*SB)'(mr_reg) * (2*SB)'(mr_reg);
            pii_reg  <= (2*SB)'(mi_reg) * (2*SB)'(mi_reg);
            neg2_reg <= {~(na_reg ^ ni_reg), na_reg ^ nr_reg};
        end
    end

    // stage 3: |b|^2
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numr_reg <= par_reg;
            numi_reg <= pai_reg;
            den3_reg <= prr_reg + pii_reg;
            neg3_reg <= neg2_reg;
        end
    end

    // stage 4: first remainders and overflow check
    assign r0r = RW'(numr_reg >> FRAC_BITS);
    assign r0i = RW'(numi_reg >> FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= r0r;
            rem_reg[1] <= r0i;
            lo_reg[0]  <= numr_reg[FRAC_BITS-1:0];
            lo_reg[1]  <= numi_reg[FRAC_BITS-1:0];
            ovf_reg[0] <= r0r >= {1'b0, den3_reg};
            ovf_reg[1] <= r0i >= {1'b0, den3_reg};
            zero_reg   <= den3_reg == '0;
            den4_reg   <= den3_reg;
            neg4_reg   <= neg3_reg;
        end
    end

    always_comb
    begin
        ctl_out.valid = valid_reg[3];
        ctl_out.last  = last_reg[3];
        ctl_out.zero  = zero_reg;
        ctl_out.ovf   = ovf_reg;
        ctl_out.neg   = neg4_reg;
    end

    assign den_out = den4_reg;
    assign rem_out = rem_reg;
    assign lo_out  = lo_reg;

endmodule

/* rtl/rbcd_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbcd_cell: one restoring division step
// Shifts in one dividend bit per lane, compares against |b|^2, subtracts
// and appends one quotient bit, then hands everything to the next cell.
// ----------------------------------------------------------------------------
module rbcd_cell #(
    parameter int SB = rbcd_pkg::SAMPLE_BITS_DEF,
    localparam int RW = 2 * SB + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  rbcd_pkg::rbcd_ctl_t    ctl_in,
    input  logic [2*SB-1:0]        den_in,
    input  logic [1:0][RW-1:0]     rem_in,
    input  logic [1:0][rbcd_pkg::FRAC_BITS-1:0] lo_in,
    input  logic [1:0][rbcd_pkg::QBITS-1:0]     q_in,
    output rbcd_pkg::rbcd_ctl_t    ctl_out,
    output logic [2*SB-1:0]        den_out,
    output logic [1:0][RW-1:0]     rem_out,
    output logic [1:0][rbcd_pkg::FRAC_BITS-1:0] lo_out,
    output logic [1:0][rbcd_pkg::QBITS-1:0]     q_out
);
    import rbcd_pkg::*;

    logic [1:0][RW-1:0]        rem_next;
    logic [1:0][QBITS-1:0]     q_next;
    logic [1:0][FRAC_BITS-1:0] lo_next;
    logic [RW-1:0]             trial [2];
    logic [1:0]                ge;
    logic                      valid_reg;
    rbcd_ctl_t                 ctl_reg;
    logic [2*SB-1:0]           den_reg;
    logic [1:0][RW-1:0]        rem_reg;
    logic [1:0][FRAC_BITS-1:0] lo_reg;
    logic [1:0][QBITS-1:0]     q_reg;

    // compare and subtract on both lanes
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            trial[l]    = {rem_in[l][RW-2:0], lo_in[l][FRAC_BITS-1]};
            ge[l]       = trial[l] >= {1'b0, den_in};
            rem_next[l] = ge[l] ? (trial[l] - {1'b0, den_in}) : trial[l];
            q_next[l]   = {q_in[l][QBITS-2:0], ge[l]};
            lo_next[l]  = {lo_in[l][FRAC_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg <= ctl_in;
            den_reg <= den_in;
            rem_reg <= rem_next;
            lo_reg  <= lo_next;
            q_reg   <= q_next;
        end
    end

    always_comb
    begin
        ctl_out       = ctl_reg;
        ctl_out.valid = valid_reg;
    end

    assign den_out = den_reg;
    assign rem_out = rem_reg;
    assign lo_out  = lo_reg;
    assign q_out   = q_reg;

endmodule

/* rtl/real_by_complex_divide.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// real_by_complex_divide: element-wise real by complex division
// r = a * conj(b) / |b|^2 with rounded, saturated Q16.16 results.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one transaction per element, tdata carries a, Re(b)
//   and Im(b) as signed samples, tlast marks the final vector element.
//   Output stream m_*: one transaction per input, tdata carries the real
//   and imaginary quotient in Q16.16, tuser the status code (ok, saturated,
//   divisor zero), tlast copied from the input.
//   The pipeline is one magnitude stage, one multiplier stage, one |b|^2
//   adder stage, one overflow check stage, 33 divider cells (one quotient
//   bit each, the last one for rounding) and the output register.
//   Throughput is one transaction per cycle without stalls; each cell is one
//   compare and subtract of 2*SAMPLE_BITS+1 bits, which sets the clock.
//   A zero divisor gives zero quotients with the divisor-zero status.
//   Reset clears all valid bits; the pipeline is empty afterwards.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module real_by_complex_divide #(
    parameter int SAMPLE_BITS = rbcd_pkg::SAMPLE_BITS_DEF,
    localparam int IN_W = ((3 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // real_dividend, divisor_real, divisor_imag, zero fill
    input  logic [IN_W-1:0]        s_tdata,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // quotient_real, quotient_imag
    output logic [2*rbcd_pkg::OUT_BITS-1:0] m_tdata,
    // status
    output logic [1:0]             m_tuser,
    output logic                   m_tlast
);
    import rbcd_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int RW = 2 * SB + 1;

    logic en;
    rbcd_ctl_t                 ctl   [QBITS+1];
    logic [2*SB-1:0]           den   [QBITS+1];
    logic [1:0][RW-1:0]        rem   [QBITS+1];
    logic [1:0][FRAC_BITS-1:0] lo    [QBITS+1];
    logic [1:0][QBITS-1:0]     q     [QBITS+1];

    logic                      valid_reg;
    logic                      last_reg;
    status_t                   status_reg, status_next;
    logic [1:0][OUT_BITS-1:0]  res_reg, res_next;
    logic [QBITS:0]            mag_ext [2];
    logic [QBITS-1:0]          mag [2];
    logic [1:0]                sat;

    // whole pipeline moves unless a result waits on a stalled receiver
    assign en       = !valid_reg || m_tready;
    assign s_tready = en;

    rbcd_front #(.SB(SB)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .a_in     (s_tdata[SB-1:0]),
        .br_in    (s_tdata[2*SB-1:SB]),
        .bi_in    (s_tdata[3*SB-1:2*SB]),
        .ctl_out  (ctl[0]),
        .den_out  (den[0]),
        .rem_out  (rem[0]),
        .lo_out   (lo[0])
    );

    assign q[0] = '0;

    // chain of divider cells
    for (genvar i = 0; i < QBITS; i++)
    begin : g_cell
        rbcd_cell #(.SB(SB)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (ctl[i]),
            .den_in  (den[i]),
            .rem_in  (rem[i]),
            .lo_in   (lo[i]),
            .q_in    (q[i]),
            .ctl_out (ctl[i+1]),
            .den_out (den[i+1]),
            .rem_out (rem[i+1]),
            .lo_out  (lo[i+1]),
            .q_out   (q[i+1])
        );
    end

    // rounding, sign and saturation
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            mag_ext[l] = {1'b0, q[QBITS][l]} + (QBITS+1)'(1);
            mag[l]     = mag_ext[l][QBITS:1];
            if (ctl[QBITS].neg[l])
            begin
                sat[l] = ctl[QBITS].ovf[l] || (mag[l] > QBITS'(33'h0_8000_0000));
                res_next[l] = sat[l] ? 32'h8000_0000
                                     : (32'd0 - mag[l][OUT_BITS-1:0]);
            end
            else
            begin
                sat[l] = ctl[QBITS].ovf[l] || (mag[l] > QBITS'(33'h0_7FFF_FFFF));
                res_next[l] = sat[l] ? 32'h7FFF_FFFF : mag[l][OUT_BITS-1:0];
            end
        end
        if (ctl[QBITS].zero)
        begin
            res_next    = '0;
            status_next = STATUS_DIV_ZERO;
        end
        else if (sat != 2'b00)
        begin
            status_next = STATUS_SAT;
        end
        else
        begin
            status_next = STATUS_OK;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctl[QBITS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg    <= res_next;
            status_reg <= status_next;
            last_reg   <= ctl[QBITS].last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

    // a zero divisor always yields zero quotients
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == STATUS_DIV_ZERO) |-> (m_tdata == '0))
        else $error("divisor zero with nonzero quotient");

    // a saturated transaction carries at least one clamped part
    a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == STATUS_SAT) |->
        (m_tdata[31:0] == 32'h7FFF_FFFF || m_tdata[31:0] == 32'h8000_0000 ||
         m_tdata[63:32] == 32'h7FFF_FFFF || m_tdata[63:32] == 32'h8000_0000))
        else $error("saturated status without clamped value");

    // stalled output holds its result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
                                     && $stable(m_tuser)))
        else $error("output changed under stall");

    // the pipeline advances exactly when the output slot is empty or being taken
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready not tied to output slot");

endmodule

/* test/real_by_complex_divide_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// real_by_complex_divide_checker: quotient predictor and result compare
// Watches both streams, computes the rounded and saturated Q16.16 quotient
// for every accepted element and compares it with the oldest pending result.
// ----------------------------------------------------------------------------
module real_by_complex_divide_checker (
    input  logic        clk,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          errors,
    output int          pending,
    output int          results_seen
);
    import rbcd_pkg::*;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        status_t     st;
        logic        last;
    } quotient_t;

    quotient_t quotient_q[$];

    // magnitude of round(num * 2^16 / den), signed and clamped to 32 bits
    function automatic logic [31:0] fixed_div(input logic [63:0] num, input logic [63:0] den,
                                              input bit neg, inout bit sat);
        logic [63:0] whole;
        logic [63:0] rem;
        logic [63:0] frac;
        logic [63:0] mag;
        whole = num / den;
        rem   = num % den;
        frac  = 0;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            rem  = rem << 1;
            frac = frac << 1;
            if (rem >= den)
            begin
                rem  = rem - den;
                frac = frac | 1;
            end
        end
        rem = rem << 1;
        if (whole > 64'h8000_0000)
            mag = 64'h8000_0001;
        else
            mag = (whole << FRAC_BITS) + frac + ((rem >= den) ? 1 : 0);
        if (neg)
        begin
            if (mag > 64'h8000_0000)
            begin
                sat = 1;
                mag = 64'h8000_0000;
            end
            return 32'(-mag);
        end
        if (mag > 64'h7FFF_FFFF)
        begin
            sat = 1;
            mag = 64'h7FFF_FFFF;
        end
        return mag[31:0];
    endfunction

    function automatic quotient_t predict_quotient(input logic [47:0] d, input logic lst);
        quotient_t   q;
        logic signed [15:0] a, br, bi;
        logic [63:0] ma, mr, mi, den;
        bit          sat;
        a  = d[15:0];
        br = d[31:16];
        bi = d[47:32];
        ma = a  < 0 ? 64'(-32'(a))  : 64'(a);
        mr = br < 0 ? 64'(-32'(br)) : 64'(br);
        mi = bi < 0 ? 64'(-32'(bi)) : 64'(bi);
        den = mr * mr + mi * mi;
        sat = 0;
        q.last = lst;
        if (den == 0)
        begin
            q.re = 0;
            q.im = 0;
            q.st = STATUS_DIV_ZERO;
            return q;
        end
        q.re = fixed_div(ma * mr, den, (a < 0) != (br < 0), sat);
        q.im = fixed_div(ma * mi, den, (a < 0) == (bi < 0), sat);
        q.st = sat ? STATUS_SAT : STATUS_OK;
        return q;
    endfunction

    initial
    begin
        errors = 0;
        pending = 0;
        results_seen = 0;
    end

    // predict on input transactions, compare on output transactions
    always @(posedge clk)
    begin
        quotient_t exp_q;
        if (s_tvalid && s_tready)
            quotient_q.push_back(predict_quotient(s_tdata, s_tlast));
        if (m_tvalid && m_tready)
        begin
            results_seen++;
            if (quotient_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result re=%h im=%h", m_tdata[31:0], m_tdata[63:32]);
            end
            else
            begin
                exp_q = quotient_q.pop_front();
                if (exp_q.re !== m_tdata[31:0] || exp_q.im !== m_tdata[63:32] ||
                    exp_q.st !== m_tuser || exp_q.last !== m_tlast)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp re=%h im=%h st=%0d last=%b got re=%h im=%h st=%0d last=%b",
                                 exp_q.re, exp_q.im, exp_q.st, exp_q.last,
                                 m_tdata[31:0], m_tdata[63:32], m_tuser, m_tlast);
                end
            end
        end
        pending = quotient_q.size();
    end

endmodule

/* test/real_by_complex_divide_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// real_by_complex_divide_tb: stream test of the real by complex divider
// Directed corner elements, then random elements over four idle phases and
// one long output hold-off; results are checked by a separate checker.
// ----------------------------------------------------------------------------
module real_by_complex_divide_tb;
    import rbcd_pkg::*;

    localparam int LATENCY  = 38;
    localparam int WDOG_MAX = 5000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int errors, pending, results_seen;
    int send_idle_pct, recv_stall_pct;
    bit hold_off;
    int idle_cycles;
    int elements_sent;

    real_by_complex_divide DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    real_by_complex_divide_checker quotient_check (
        .clk(clk),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .errors(errors), .pending(pending), .results_seen(results_seen)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, or a long hold-off
    always @(negedge clk)
        m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($urandom_range(7)) - 16'd3;
            default: return 16'($urandom);
        endcase
    endfunction

    // offer one element and wait until it is taken; valid stays up so the
    // next call can follow back to back
    task automatic send_element(input logic [15:0] a, input logic [15:0] br,
                                input logic [15:0] bi, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {bi, br, a};
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        elements_sent++;
        @(negedge clk);
    endtask

    initial
    begin
        logic [15:0] corner [6];
        corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h4000};
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tlast = 0;
        m_tready = 0;
        hold_off = 0;
        idle_cycles = 0;
        elements_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed corners: extremes, zero divisor, tiny divisor saturation
        send_element(16'h0000, 16'h0000, 16'h0000, 1);
        send_element(16'h7FFF, 16'h0000, 16'h0000, 0);
        send_element(16'h8000, 16'h0001, 16'h0000, 0);
        send_element(16'h7FFF, 16'h0001, 16'h0000, 0);
        send_element(16'h8000, 16'h0000, 16'hFFFF, 0);
        send_element(16'h7FFF, 16'h8000, 16'h8000, 0);
        send_element(16'h8000, 16'h8000, 16'h0000, 0);
        send_element(16'h0001, 16'h0003, 16'h0000, 0);
        send_element(16'hFFFF, 16'h0000, 16'h0003, 0);
        send_element(16'h0001, 16'h0002, 16'h0002, 0);
        send_element(16'hFFFF, 16'hFFFE, 16'h0002, 1);
        for (int i = 0; i < 12; i++)
            send_element(corner[$urandom_range(5)], corner[$urandom_range(5)],
                         corner[$urandom_range(5)], i[0]);

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 54 : (ph == 3) ? 14 : 0;
            recv_stall_pct = (ph == 2) ? 54 : (ph == 3) ? 14 : 0;
            if (ph == 2)
            begin
                // long hold-off while the sender keeps offering
                fork
                    begin
                        hold_off = 1;
                        repeat (120) @(posedge clk);
                        hold_off = 0;
                    end
                    for (int k = 0; k < 60; k++)
                        send_element(pick_sample(), pick_sample(), pick_sample(),
                                     $urandom_range(15) == 0);
                join
            end
            for (int k = 0; k < 370; k++)
                send_element(pick_sample(), pick_sample(), pick_sample(),
                             $urandom_range(15) == 0);
        end
        s_tvalid <= 0;

        recv_stall_pct = 0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        $display("covered %0d elements, %0d results: corners, zero divisors, saturation",
                 elements_sent, results_seen);
        $display("idle phases: none, sender 54%%, receiver 54%%, both 14%%, long hold-off");
        if (errors == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
rtl/rbcd_pkg.sv
rtl/rbcd_front.sv
rtl/rbcd_cell.sv
rtl/real_by_complex_divide.sv
test/real_by_complex_divide_checker.sv
test/real_by_complex_divide_tb.sv
